// ===== rtl/core/lpht_pkg.sv =====
package lpht_pkg;

  // Field widths fixed by the item format.
  localparam int KEY_W  = 31;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // Width of the table size register and of every ring position.
  localparam int SIZE_W = 5;

  // Defaults.
  localparam int                MAX_SLOTS_DEF  = 16;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd10;

  // Register index of the table size register.
  localparam logic REG_TABLE_SIZE = 1'b0;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  // Access request from the sequencer to the slot store.
  typedef struct packed {
    logic [SIZE_W-1:0] addr;
    logic              wr_en;
    logic              clr_en;
  } store_cmd_t;

endpackage

// ===== rtl/core/lpht_mod_unit.sv =====
// Iterative remainder unit: key mod n, four key bits per cycle.
module lpht_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  input  logic [lpht_pkg::SIZE_W-1:0]   n,
  output logic                          done,
  output logic [lpht_pkg::SIZE_W-1:0]   rem
);

  localparam int STEP_BITS = 4;
  localparam int SHIFT_W   = 32;
  localparam int STEPS     = SHIFT_W / STEP_BITS;
  localparam int CNT_W     = $clog2(STEPS);

  logic [SHIFT_W-1:0]          kshift;
  logic [CNT_W-1:0]            cnt;
  logic                        active;
  logic [lpht_pkg::SIZE_W-1:0] rem_next;
  logic [lpht_pkg::SIZE_W:0]   trial;

  // Four restoring steps on the running remainder, most significant bit first.
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      trial = {rem_next, kshift[SHIFT_W-1-j]};
      if (trial >= {1'b0, n}) begin
        trial = trial - {1'b0, n};
      end
      rem_next = trial[lpht_pkg::SIZE_W-1:0];
    end
  end

  // Step control and the remainder register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kshift <= {1'b0, key};
      rem    <= '0;
    end else if (active) begin
      kshift <= kshift << STEP_BITS;
      rem    <= rem_next;
    end
  end

endmodule

// ===== rtl/core/lpht_store.sv =====
// Slot store: key and payload memory with registered read, plus used bits.
module lpht_store #(
  parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpht_pkg::store_cmd_t          req,
  input  logic [lpht_pkg::KEY_W-1:0]    wr_key,
  input  logic [lpht_pkg::DATA_W-1:0]   wr_data,
  output logic [lpht_pkg::KEY_W-1:0]    rd_key,
  output logic [lpht_pkg::DATA_W-1:0]   rd_data,
  output logic                          rd_used
);

  localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int WORD_W = lpht_pkg::KEY_W + lpht_pkg::DATA_W;

  logic [WORD_W-1:0]    mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] used;
  logic [AW-1:0]        addr;
  logic [WORD_W-1:0]    rd_word;

  assign addr = AW'(req.addr);

  // Key and payload memory: a registered read every cycle, plus a write when wr_en is set.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= {wr_data, wr_key};
    end
    rd_word <= mem[addr];
  end

  assign rd_key  = rd_word[lpht_pkg::KEY_W-1:0];
  assign rd_data = rd_word[WORD_W-1:lpht_pkg::KEY_W];

  // Used bits: cleared at reset, set on insert, cleared on delete.
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      rd_used <= 1'b0;
    end else begin
      if (req.wr_en) begin
        used[addr] <= 1'b1;
      end else if (req.clr_en) begin
        used[addr] <= 1'b0;
      end
      rd_used <= used[addr];
    end
  end

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
// Channel   Dir  Beat fields (lowest bit first)
// s_*       in   tdata: cmd[1:0], key[32:2], record_data[64:33], zero pad to 72
// m_*       out  tdata: status[1:0], slot[5:2], found_data[37:6], zero pad to 40
// APB       in   table_size at byte address 0, bits [4:0]
//
// Each command runs the remainder unit for the home slot, then a ring scan
// of n slots, n being the table size in use, through the store's read port
// at one slot per cycle, then a drain of the read and a final step that
// updates the store and loads the result. The next beat can be taken in the
// cycle after the final step; no beat is taken while a command is in flight.
// Reset clears the used bits, the table size (to 10), the sequencer state and flags,
// and holds the input side not ready.
// A new beat is taken while a result still waits; a stalled result holds
// the sequencer in its final step.
module linear_probe_hash_table #(
  parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // cmd[1:0], key[32:2], record_data[64:33]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,
  // status[1:0], slot[5:2], found_data[37:6]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = lpht_pkg::SIZE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                      state;
  logic [SW-1:0]                   table_size;
  logic [SW-1:0]                   n_eff;
  logic [SW-1:0]                   n_q;
  logic [lpht_pkg::CMD_W-1:0]      cmd_q;
  logic [lpht_pkg::KEY_W-1:0]      key_q;
  logic [lpht_pkg::DATA_W-1:0]     data_q;
  logic [SW-1:0]                   pos;
  logic [SW-1:0]                   cnt;
  logic                            pend;
  logic                            found;
  logic [SW-1:0]                   found_pos;
  logic [lpht_pkg::DATA_W-1:0]     found_pay;
  logic                            have_free;
  logic [SW-1:0]                   free_pos;
  logic                            accept;
  logic                            finish_go;
  logic                            mod_done;
  logic [SW-1:0]                   mod_rem;
  lpht_pkg::store_cmd_t            store_req;
  logic [lpht_pkg::KEY_W-1:0]      rd_key;
  logic [lpht_pkg::DATA_W-1:0]     rd_data;
  logic                            rd_used;
  logic [lpht_pkg::STAT_W-1:0]     status;
  logic [lpht_pkg::SLOT_W-1:0]     slot;
  logic [lpht_pkg::DATA_W-1:0]     found_data;
  logic [lpht_pkg::STAT_W-1:0]     status_next;
  logic [SW-1:0]                   slot_next;
  logic [lpht_pkg::DATA_W-1:0]     found_data_next;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lpht_pkg::REG_TABLE_SIZE) ? {27'd0, table_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= lpht_pkg::TABLE_SIZE_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == lpht_pkg::REG_TABLE_SIZE) begin
      table_size <= pwdata[SW-1:0];
    end
  end

  // Size in use: zero counts as one slot, large sizes saturate.
  always_comb begin
    if (table_size == '0) begin
      n_eff = SW'(1);
    end else if (32'(table_size) > 32'(MAX_SLOTS)) begin
      n_eff = SW'(MAX_SLOTS);
    end else begin
      n_eff = table_size;
    end
  end

  assign s_tready  = (state == S_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign finish_go = (state == S_FINISH) && (!m_tvalid || m_tready);

  // Home slot from the remainder unit.
  lpht_mod_unit u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (s_tdata[32:2]),
    .n     (n_q),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Store access: scan reads at pos; the final step writes or frees a slot.
  always_comb begin
    store_req.addr   = pos;
    store_req.wr_en  = 1'b0;
    store_req.clr_en = 1'b0;
    if (finish_go) begin
      if (cmd_q == lpht_pkg::CMD_DELETE) begin
        store_req.addr   = found_pos;
        store_req.clr_en = found;
      end else begin
        store_req.addr  = free_pos;
        store_req.wr_en = (cmd_q == lpht_pkg::CMD_INSERT) && !found && have_free;
      end
    end
  end

  lpht_store #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .wr_key  (key_q),
    .wr_data (data_q),
    .rd_key  (rd_key),
    .rd_data (rd_data),
    .rd_used (rd_used)
  );

  // Result of the scan for the held command.
  always_comb begin
    status_next     = lpht_pkg::ST_MISSING;
    slot_next       = '0;
    found_data_next = '0;
    case (cmd_q)
      lpht_pkg::CMD_INSERT: begin
        if (found) begin
          status_next = lpht_pkg::ST_DUP;
        end else if (have_free) begin
          status_next = lpht_pkg::ST_DONE;
          slot_next   = free_pos;
        end else begin
          status_next = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::CMD_LOOKUP: begin
        if (found) begin
          status_next     = lpht_pkg::ST_DONE;
          slot_next       = found_pos;
          found_data_next = found_pay;
        end
      end
      lpht_pkg::CMD_DELETE: begin
        if (found) begin
          status_next = lpht_pkg::ST_DONE;
          slot_next   = found_pos;
        end
      end
      default: begin
        status_next = lpht_pkg::ST_MISSING;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= 1'b1;
          if (cnt == n_q - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (finish_go) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Held command, probe position and scan count.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= s_tdata[1:0];
      key_q  <= s_tdata[32:2];
      data_q <= s_tdata[64:33];
      n_q    <= n_eff;
    end
    if (state == S_MOD && mod_done) begin
      pos <= mod_rem;
      cnt <= '0;
    end else if (state == S_SCAN) begin
      pos <= (pos + 1'b1 == n_q) ? '0 : pos + 1'b1;
      cnt <= cnt + 1'b1;
    end
  end

  // Compare stage: one slot's read data per cycle, from the read issued at pos in the cycle before.
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (pend) begin
      if (rd_used && rd_key == key_q) begin
        found <= 1'b1;
      end
      if (!rd_used && !have_free) begin
        have_free <= 1'b1;
      end
    end
  end

  // Slot being compared trails the read address by one; the first match
  // from home is the one kept.
  always_ff @(posedge clk) begin
    if (pend && !found && rd_used && rd_key == key_q) begin
      found_pos <= (pos == '0) ? n_q - 1'b1 : pos - 1'b1;
      found_pay <= rd_data;
    end
    if (pend && !rd_used && !have_free) begin
      free_pos <= (pos == '0) ? n_q - 1'b1 : pos - 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (finish_go) begin
      status     <= status_next;
      slot       <= slot_next[lpht_pkg::SLOT_W-1:0];
      found_data <= found_data_next;
    end
  end

  assign m_tdata = {2'b00, found_data, slot, status};

endmodule
